// ===== rtl/hfd_pkg.sv =====
// Package for the sixteen-symbol Huffman decoder.
// Holds field widths, register indexes, builder states and shared structs.
// No dependencies.
package hfd_pkg;

  localparam int MAX_SYMS  = 16;
  localparam int SYM_W     = 4;
  localparam int FREQ_W    = 8;
  localparam int NODE_W    = 5;
  localparam int SUM_W     = 12;
  localparam int CODE_W    = 15;
  localparam int LEN_W     = 4;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FREQ_LOW  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_HIGH = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_LOAD  = 3'b010,
    ST_MERGE = 3'b100
  } build_state_t;

  typedef struct packed {
    logic [NODE_W-1:0] id;
    logic [SUM_W-1:0]  fr;
  } node_t;

  typedef struct packed {
    logic              present;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } code_entry_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [LEN_W-1:0] bits_used;
    logic             empty_error;
  } match_t;

endpackage

// ===== rtl/hfd_in_if.sv =====
// Input channel of the Huffman decoder: valid, ready and the bit window.
// Depends on hfd_pkg.
interface hfd_in_if;
  logic                        valid;
  logic                        ready;
  logic [hfd_pkg::CODE_W-1:0]  bit_window;

  modport source (output valid, output bit_window, input ready);
  modport sink   (input valid, input bit_window, output ready);
endinterface

// ===== rtl/hfd_out_if.sv =====
// Result channel of the Huffman decoder: valid, ready and the decoded fields.
// Depends on hfd_pkg.
interface hfd_out_if;
  logic                       valid;
  logic                       ready;
  logic [hfd_pkg::SYM_W-1:0]  symbol;
  logic [hfd_pkg::LEN_W-1:0]  bits_used;
  logic                       empty_error;

  modport source (output valid, output symbol, output bits_used, output empty_error,
                  input ready);
  modport sink   (input valid, input symbol, input bits_used, input empty_error,
                  output ready);
endinterface

// ===== rtl/hfd_builder.sv =====
// Frequency registers and the code builder sequencer of the Huffman decoder.
// One symbol is sorted in per cycle, then one merge per cycle. Depends on hfd_pkg.
module hfd_builder #(
  parameter int SYMBOL_COUNT = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hfd_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                           busy,
  output hfd_pkg::code_entry_t           code_tab [SYMBOL_COUNT]
);

  localparam int CNT_W = $clog2(SYMBOL_COUNT + 1);
  localparam int SIX_W = $clog2(SYMBOL_COUNT);

  hfd_pkg::build_state_t state_r, state_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [SIX_W-1:0]           sym_r, sym_nxt;
  logic [hfd_pkg::NODE_W-1:0] next_r, next_nxt;
  logic [hfd_pkg::CFG_W-1:0]  freq_lo_r, freq_hi_r;
  hfd_pkg::node_t             slot_r [SYMBOL_COUNT];
  hfd_pkg::node_t             slot_nxt [SYMBOL_COUNT];
  logic [hfd_pkg::NODE_W-1:0] top_r [SYMBOL_COUNT];
  logic [hfd_pkg::NODE_W-1:0] top_nxt [SYMBOL_COUNT];
  logic [hfd_pkg::CODE_W-1:0] code_r [SYMBOL_COUNT];
  logic [hfd_pkg::CODE_W-1:0] code_nxt [SYMBOL_COUNT];
  logic [hfd_pkg::LEN_W-1:0]  len_r [SYMBOL_COUNT];
  logic [hfd_pkg::LEN_W-1:0]  len_nxt [SYMBOL_COUNT];
  logic [hfd_pkg::FREQ_W-1:0] fr_sym [SYMBOL_COUNT];

  hfd_pkg::node_t   base [SYMBOL_COUNT];
  hfd_pkg::node_t   ins [SYMBOL_COUNT];
  hfd_pkg::node_t   new_node;
  logic [CNT_W-1:0] nb;
  logic             le [SYMBOL_COUNT];
  logic             rebuild;

  for (genvar k = 0; k < SYMBOL_COUNT; k++) begin : g_sym
    if (k < 8) begin : g_lo
      assign fr_sym[k] = freq_lo_r[k*8 +: 8];
    end else begin : g_hi
      assign fr_sym[k] = freq_hi_r[(k-8)*8 +: 8];
    end
    assign code_tab[k].present = (fr_sym[k] != '0);
    assign code_tab[k].len     = len_r[k];
    assign code_tab[k].code    = code_r[k];
  end

  assign busy    = (state_r != hfd_pkg::ST_IDLE);
  assign rebuild = cfg_we && ((cfg_index == hfd_pkg::REG_FREQ_LOW) ||
                              (cfg_index == hfd_pkg::REG_FREQ_HIGH));

  // The list is kept smallest first; a new node goes ahead of (at a lower index than) any equal node.
  always_comb begin
    if (state_r == hfd_pkg::ST_LOAD) begin
      for (int j = 0; j < SYMBOL_COUNT; j++) base[j] = slot_r[j];
      nb          = cnt_r;
      new_node.id = hfd_pkg::NODE_W'(sym_r);
      new_node.fr = hfd_pkg::SUM_W'(fr_sym[sym_r]);
    end else begin
      for (int j = 0; j < SYMBOL_COUNT; j++) begin
        base[j] = (j + 2 < SYMBOL_COUNT) ? slot_r[(j + 2) % SYMBOL_COUNT] : slot_r[j];
      end
      nb          = cnt_r - CNT_W'(2);
      new_node.id = next_r;
      new_node.fr = slot_r[0].fr + slot_r[1].fr;
    end
    for (int j = 0; j < SYMBOL_COUNT; j++) begin
      le[j] = (CNT_W'(j) < nb) && (base[j].fr < new_node.fr);
    end
    for (int j = 0; j < SYMBOL_COUNT; j++) begin
      if (le[j]) begin
        ins[j] = base[j];
      end else if (j == 0) begin
        ins[j] = new_node;
      end else if (le[j-1]) begin
        ins[j] = new_node;
      end else begin
        ins[j] = base[j-1];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sym_nxt   = sym_r;
    next_nxt  = next_r;
    for (int j = 0; j < SYMBOL_COUNT; j++) begin
      slot_nxt[j] = slot_r[j];
      top_nxt[j]  = top_r[j];
      code_nxt[j] = code_r[j];
      len_nxt[j]  = len_r[j];
    end
    if (rebuild) begin
      state_nxt = hfd_pkg::ST_LOAD;
      cnt_nxt   = '0;
      sym_nxt   = '0;
      next_nxt  = hfd_pkg::NODE_W'(hfd_pkg::MAX_SYMS);
      for (int j = 0; j < SYMBOL_COUNT; j++) begin
        top_nxt[j]  = hfd_pkg::NODE_W'(j);
        code_nxt[j] = '0;
        len_nxt[j]  = '0;
      end
    end else begin
      unique case (state_r)
        hfd_pkg::ST_IDLE: begin
        end
        hfd_pkg::ST_LOAD: begin
          if (fr_sym[sym_r] != '0) begin
            for (int j = 0; j < SYMBOL_COUNT; j++) slot_nxt[j] = ins[j];
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          sym_nxt = sym_r + SIX_W'(1);
          if (sym_r == SIX_W'(SYMBOL_COUNT - 1)) begin
            state_nxt = hfd_pkg::ST_MERGE;
          end
        end
        hfd_pkg::ST_MERGE: begin
          if (cnt_r < CNT_W'(2)) begin
            state_nxt = hfd_pkg::ST_IDLE;
          end else begin
            for (int j = 0; j < SYMBOL_COUNT; j++) slot_nxt[j] = ins[j];
            cnt_nxt  = cnt_r - CNT_W'(1);
            next_nxt = next_r + hfd_pkg::NODE_W'(1);
            for (int j = 0; j < SYMBOL_COUNT; j++) begin
              if (top_r[j] == slot_r[0].id) begin
                code_nxt[j] = {code_r[j][hfd_pkg::CODE_W-2:0], 1'b0};
                len_nxt[j]  = len_r[j] + hfd_pkg::LEN_W'(1);
                top_nxt[j]  = next_r;
              end else if (top_r[j] == slot_r[1].id) begin
                code_nxt[j] = {code_r[j][hfd_pkg::CODE_W-2:0], 1'b1};
                len_nxt[j]  = len_r[j] + hfd_pkg::LEN_W'(1);
                top_nxt[j]  = next_r;
              end
            end
          end
        end
        default: state_nxt = hfd_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hfd_pkg::ST_IDLE;
      cnt_r     <= '0;
      sym_r     <= '0;
      next_r    <= '0;
      freq_lo_r <= '0;
      freq_hi_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sym_r   <= sym_nxt;
      next_r  <= next_nxt;
      if (cfg_we && (cfg_index == hfd_pkg::REG_FREQ_LOW)) freq_lo_r <= cfg_wdata;
      if (cfg_we && (cfg_index == hfd_pkg::REG_FREQ_HIGH)) freq_hi_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < SYMBOL_COUNT; j++) begin
      slot_r[j] <= slot_nxt[j];
      top_r[j]  <= top_nxt[j];
      code_r[j] <= code_nxt[j];
      len_r[j]  <= len_nxt[j];
    end
  end

endmodule

// ===== rtl/hfd_matcher.sv =====
// Parallel code matcher of the Huffman decoder: compares a window against all
// masked codes and picks the lowest matching present symbol. Depends on hfd_pkg.
module hfd_matcher #(
  parameter int SYMBOL_COUNT = 16
) (
  input  logic [hfd_pkg::CODE_W-1:0] bit_window,
  input  hfd_pkg::code_entry_t       code_tab [SYMBOL_COUNT],
  output hfd_pkg::match_t            result
);

  logic [hfd_pkg::CODE_W:0] mask_w [SYMBOL_COUNT];

  always_comb begin
    result.symbol      = '0;
    result.bits_used   = '0;
    result.empty_error = 1'b1;
    for (int s = SYMBOL_COUNT - 1; s >= 0; s--) begin
      mask_w[s] = ((hfd_pkg::CODE_W + 1)'(1) << code_tab[s].len) - (hfd_pkg::CODE_W + 1)'(1);
      if (code_tab[s].present &&
          ((bit_window & mask_w[s][hfd_pkg::CODE_W-1:0]) ==
           (code_tab[s].code & mask_w[s][hfd_pkg::CODE_W-1:0]))) begin
        result.symbol      = hfd_pkg::SYM_W'(s);
        result.bits_used   = code_tab[s].len;
        result.empty_error = 1'b0;
      end
    end
  end

endmodule

// ===== rtl/huffman_decode_from_frequencies_top.sv =====
// Huffman decoder for up to sixteen symbols whose code is built from byte
// frequencies. A write to either frequency register starts a rebuild that sorts
// in each symbol in turn and then merges nodes pairwise, during which the input
// is not ready; after that one window is decoded per cycle while the result
// channel does not stall, and the result of the parallel code matcher is held
// in the result register.
// Depends on hfd_pkg, hfd_in_if, hfd_out_if, hfd_builder and hfd_matcher.
module huffman_decode_from_frequencies_top #(
  parameter int SYMBOL_COUNT = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hfd_pkg::CFG_W-1:0]      cfg_wdata,
  hfd_in_if.sink                         in_chan,
  hfd_out_if.source                      out_chan
);

  hfd_pkg::code_entry_t code_tab [SYMBOL_COUNT];
  hfd_pkg::match_t      match;
  hfd_pkg::match_t      res_r;
  logic                 out_valid_r;
  logic                 busy;
  logic                 in_xfer;

  hfd_builder #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_builder (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .busy      (busy),
    .code_tab  (code_tab)
  );

  hfd_matcher #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_matcher (
    .bit_window (in_chan.bit_window),
    .code_tab   (code_tab),
    .result     (match)
  );

  assign in_chan.ready = !busy && (!out_valid_r || out_chan.ready);
  assign in_xfer       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= match;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.symbol      = res_r.symbol;
  assign out_chan.bits_used   = res_r.bits_used;
  assign out_chan.empty_error = res_r.empty_error;

endmodule

// ===== dv/huffman_decode_from_frequencies_top_test.sv =====
// Testbench for the sixteen-symbol Huffman decoder top level.
// Builds its own code from the frequency registers, predicts each decode and
// checks every result transfer; depends on hfd_pkg, hfd_in_if, hfd_out_if and the top level.
`timescale 1ns / 1ps

module huffman_decode_from_frequencies_top_test;

  localparam int SYMBOL_COUNT = 16;
  localparam int NODES = 32;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [hfd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd7;

  typedef struct {
    bit              reconfig;
    logic [63:0]     lo;
    logic [63:0]     hi;
    logic [14:0]     win;
    bit              known;
    hfd_pkg::match_t want;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [hfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hfd_pkg::CFG_W-1:0] cfg_wdata = '0;

  hfd_in_if in_chan ();
  hfd_out_if out_chan ();

  huffman_decode_from_frequencies_top #(.SYMBOL_COUNT(SYMBOL_COUNT)) i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  always #2 clk = ~clk;

  logic [63:0] freq_lo, freq_hi;
  int code_len[16];
  int code_val[16];
  int node_fr[NODES];
  int node_up[NODES];
  int node_br[NODES];
  bit node_has_up[NODES];
  int order[NODES];
  int order_n;

  hfd_pkg::match_t pending_decodes[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  vector_t vectors[$];

  function automatic int freq_of(int s);
    logic [63:0] r;
    r = (s < 8) ? freq_lo : freq_hi;
    return int'((r >> ((s % 8) * 8)) & 64'hFF);
  endfunction

  function automatic void sorted_insert(int node);
    int pos;
    pos = order_n;
    for (int i = 0; i < order_n; i++) begin
      if (node_fr[node] > node_fr[order[i]]) begin
        pos = i;
        break;
      end
    end
    for (int i = order_n; i > pos; i--) order[i] = order[i-1];
    order[pos] = node;
    order_n++;
  endfunction

  function automatic void rebuild_code();
    int nxt, a, b, c, depth, v, k, val;
    nxt = 16;
    order_n = 0;
    for (int s = 0; s < NODES; s++) begin
      node_fr[s] = 0; node_up[s] = 0; node_br[s] = 0; node_has_up[s] = 1'b0;
    end
    for (int s = 0; s < 16; s++) begin
      code_len[s] = 0; code_val[s] = 0;
    end
    for (int s = 0; s < SYMBOL_COUNT; s++) begin
      if (freq_of(s) != 0) begin
        node_fr[s] = freq_of(s);
        sorted_insert(s);
      end
    end
    while (order_n > 1 && nxt < NODES) begin
      a = order[order_n-1];
      b = order[order_n-2];
      c = nxt++;
      order_n -= 2;
      node_fr[c] = node_fr[a] + node_fr[b];
      node_up[a] = c; node_br[a] = 0; node_has_up[a] = 1'b1;
      node_up[b] = c; node_br[b] = 1; node_has_up[b] = 1'b1;
      sorted_insert(c);
    end
    for (int s = 0; s < SYMBOL_COUNT; s++) begin
      if (freq_of(s) == 0) continue;
      depth = 0;
      v = s;
      while (node_has_up[v] && depth < 15) begin
        depth++;
        v = node_up[v];
      end
      v = s;
      k = depth;
      val = 0;
      while (node_has_up[v] && k > 0) begin
        k--;
        val |= node_br[v] << k;
        v = node_up[v];
      end
      code_len[s] = depth;
      code_val[s] = val & 16'h7FFF;
    end
  endfunction

  function automatic hfd_pkg::match_t decode_window(logic [14:0] win);
    hfd_pkg::match_t m;
    int mask;
    for (int s = 0; s < SYMBOL_COUNT; s++) begin
      if (freq_of(s) == 0) continue;
      mask = (1 << code_len[s]) - 1;
      if ((int'(win) & mask) == (code_val[s] & mask)) begin
        m.symbol = s[3:0];
        m.bits_used = code_len[s][3:0];
        m.empty_error = 1'b0;
        return m;
      end
    end
    m.symbol = '0;
    m.bits_used = '0;
    m.empty_error = 1'b1;
    return m;
  endfunction

  task automatic write_reg(logic [hfd_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    in_chan.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == hfd_pkg::REG_FREQ_LOW) freq_lo = data;
    else if (idx == hfd_pkg::REG_FREQ_HIGH) freq_hi = data;
    else return;
    rebuild_code();
  endtask

  task automatic load_freqs(logic [63:0] lo, logic [63:0] hi);
    write_reg(hfd_pkg::REG_FREQ_LOW, lo);
    write_reg(hfd_pkg::REG_FREQ_HIGH, hi);
  endtask

  task automatic send_window(logic [14:0] win, bit known, hfd_pkg::match_t want);
    hfd_pkg::match_t m;
    bit acc;
    if (!calm && $urandom_range(99) < 18) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.bit_window <= win;
    do begin
      @(negedge clk);
      acc = in_chan.ready;
      @(posedge clk);
    end while (!acc);
    m = decode_window(win);
    if (known && m != want) begin
      $display("%0t: table entry disagrees with prediction: expected %p, actual %p",
               $time, want, m);
      errors++;
    end
    pending_decodes.push_back(m);
  endtask

  function automatic logic [63:0] random_freqs(int mode);
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    case (mode)
      0: ;
      1: for (int i = 0; i < 8; i++) if ($urandom_range(1)) r[i*8 +: 8] = 8'h00;
      2: begin
        r = '0;
        r[$urandom_range(7)*8 +: 8] = 8'($urandom_range(1, 255));
      end
      3: r = $urandom_range(1) ? {64{1'b1}} : 64'h0101010101010101;
      default: r = '0;
    endcase
    return r;
  endfunction

  always @(negedge clk) begin
    hfd_pkg::match_t got, want;
    if (out_chan.valid && out_chan.ready) begin
      got.symbol = out_chan.symbol;
      got.bits_used = out_chan.bits_used;
      got.empty_error = out_chan.empty_error;
      if (pending_decodes.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %p", $time, got);
        errors++;
      end else begin
        want = pending_decodes.pop_front();
        if (got.symbol != want.symbol)
          $display("%0t: symbol expected %0d, actual %0d", $time, want.symbol, got.symbol);
        if (got.bits_used != want.bits_used)
          $display("%0t: bits_used expected %0d, actual %0d", $time, want.bits_used,
                   got.bits_used);
        if (got.empty_error != want.empty_error)
          $display("%0t: empty_error expected %0b, actual %0b", $time, want.empty_error,
                   got.empty_error);
        if (got != want) errors++;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_request <= 1'b0;
      hold_left <= 200;
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_chan.ready <= (hold_left == 1);
    end else begin
      out_chan.ready <= calm || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("huffman_decode_from_frequencies_top_test: done, errors");
      $finish;
    end
  end

  function automatic vector_t row(bit rc, logic [63:0] lo, logic [63:0] hi,
                                  logic [14:0] win, bit known, hfd_pkg::match_t want);
    vector_t v;
    v.reconfig = rc; v.lo = lo; v.hi = hi; v.win = win; v.known = known; v.want = want;
    return v;
  endfunction

  initial begin
    hfd_pkg::match_t empty_m, none;
    empty_m = '{symbol: 4'd0, bits_used: 4'd0, empty_error: 1'b1};
    none = '0;
    in_chan.valid = 1'b0;
    in_chan.bit_window = '0;
    out_chan.ready = 1'b0;
    freq_lo = '0;
    freq_hi = '0;
    rebuild_code();

    vectors.push_back(row(0, 0, 0, 15'h0000, 1, empty_m));
    vectors.push_back(row(0, 0, 0, 15'h7FFF, 1, empty_m));
    vectors.push_back(row(1, 64'h0500, 0, 15'h7FFF, 1, '{4'd1, 4'd0, 1'b0}));
    vectors.push_back(row(0, 0, 0, 15'h0000, 1, '{4'd1, 4'd0, 1'b0}));
    vectors.push_back(row(1, 0, 64'hFF00_0000_0000_0000, 15'h1234, 1, '{4'd15, 4'd0, 1'b0}));
    vectors.push_back(row(1, {64{1'b1}}, {64{1'b1}}, 15'h0000, 0, none));
    vectors.push_back(row(0, 0, 0, 15'h7FFF, 0, none));
    vectors.push_back(row(0, 0, 0, 15'h5555, 0, none));
    vectors.push_back(row(0, 0, 0, 15'h2AAA, 0, none));
    vectors.push_back(row(1, 64'h150D080503020101, 64'h000000E990593722, 15'h0000, 0, none));
    vectors.push_back(row(0, 0, 0, 15'h7FFF, 0, none));
    vectors.push_back(row(0, 0, 0, 15'h0FFF, 0, none));
    vectors.push_back(row(0, 0, 0, 15'h1000, 0, none));
    vectors.push_back(row(0, 0, 0, 15'h07FF, 0, none));
    vectors.push_back(row(1, 64'h0101, 0, 15'h0000, 0, none));
    vectors.push_back(row(0, 0, 0, 15'h0001, 0, none));
    vectors.push_back(row(1, 0, 0, 15'h7FFF, 1, empty_m));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) begin
      if (vectors[i].reconfig) load_freqs(vectors[i].lo, vectors[i].hi);
      send_window(vectors[i].win, vectors[i].known, vectors[i].want);
    end

    write_reg(REG_UNUSED, {64{1'b1}});
    send_window(15'h2A5A, 1, empty_m);

    for (int phase = 0; phase < 11; phase++) begin
      in_chan.valid <= 1'b0;
      load_freqs(random_freqs(phase % 4), random_freqs((phase + phase / 4) % 4));
      calm = (phase == 1);
      for (int n = 0; n < 58; n++) begin
        if (phase == 3 && n == 5) hold_request = 1'b1;
        send_window(15'($urandom()), 0, none);
      end
    end
    calm = 1'b0;
    in_chan.valid <= 1'b0;

    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("huffman_decode_from_frequencies_top_test: done, clean");
    end else begin
      $display("huffman_decode_from_frequencies_top_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hfd_pkg.sv
rtl/hfd_in_if.sv
rtl/hfd_out_if.sv
rtl/hfd_builder.sv
rtl/hfd_matcher.sv
rtl/huffman_decode_from_frequencies_top.sv
dv/huffman_decode_from_frequencies_top_test.sv
